// File: rtl/core/square_spiral_index_generator_assert.svh
// assertion macros for the spiral generator rtl
`ifndef SQUARE_SPIRAL_INDEX_GENERATOR_ASSERT_SVH
`define SQUARE_SPIRAL_INDEX_GENERATOR_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, sampled on clock, off during reset
`define SSIG_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("spiral generator assertion failed");

// next-cycle implication, sampled on clock, off during reset
`define SSIG_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("spiral generator assertion failed");

`else

`define SSIG_ASSERT_NOW(lbl, ante, cons)
`define SSIG_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// File: rtl/core/ssig_pkg.sv
package ssig_pkg;

   // field widths of the streams and the register
   localparam int CENTER_W = 16;
   localparam int NEED_W   = 6;
   localparam int IDX_W    = 18;
   localparam int CFG_W    = 9;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 24;

   // defaults for the top level parameters
   localparam int MAX_STEPS_DEF     = 63;
   localparam int MAX_ROW_WIDTH_DEF = 256;

   // row width after reset
   localparam logic [CFG_W-1:0] ROW_WIDTH_RST = 9'd16;

   // walk direction
   typedef enum logic [1:0] {
      HEAD_RIGHT = 2'd0,
      HEAD_DOWN  = 2'd1,
      HEAD_LEFT  = 2'd2,
      HEAD_UP    = 2'd3
   } heading_type;

   // microprogram step address
   typedef logic [1:0] step_type;
   localparam step_type STEP_IDLE   = 2'd0;
   localparam step_type STEP_CENTER = 2'd1;
   localparam step_type STEP_WALK   = 2'd2;

   // branch condition of a control word
   typedef enum logic [1:0] {
      COND_ALWAYS = 2'd0,
      COND_ACCEPT = 2'd1,
      COND_LAST   = 2'd2
   } cond_type;

   // datapath controls of one step
   typedef struct packed {
      logic accept;
      logic emit;
      logic move;
   } ctl_type;

   // one control word
   typedef struct packed {
      ctl_type  ctl;
      cond_type cond;
      step_type jump_to;
      step_type next_to;
   } uword_type;

   // datapath status seen by the sequencer
   typedef struct packed {
      logic req_valid;
      logic slot_free;
      logic last;
   } status_type;

   // microprogram rom
   function automatic uword_type ucode(input step_type step);
      uword_type w;
      unique case (step)
         // wait for a request and load it
         STEP_IDLE:   w = '{ctl: '{accept: 1'b1, emit: 1'b0, move: 1'b0},
                            cond: COND_ACCEPT, jump_to: STEP_CENTER, next_to: STEP_IDLE};
         // emit the centre tile
         STEP_CENTER: w = '{ctl: '{accept: 1'b0, emit: 1'b1, move: 1'b0},
                            cond: COND_LAST, jump_to: STEP_IDLE, next_to: STEP_WALK};
         // one spiral step per cycle while the output register is free, until the count runs out
         STEP_WALK:   w = '{ctl: '{accept: 1'b0, emit: 1'b1, move: 1'b1},
                            cond: COND_LAST, jump_to: STEP_IDLE, next_to: STEP_WALK};
         default:     w = '{ctl: '{accept: 1'b0, emit: 1'b0, move: 1'b0},
                            cond: COND_ALWAYS, jump_to: STEP_IDLE, next_to: STEP_IDLE};
      endcase
      return w;
   endfunction

endpackage

// File: rtl/core/ssig_seq.sv
module ssig_seq (
   input  logic                clock,
   input  logic                reset,
   input  ssig_pkg::status_type status,
   output ssig_pkg::ctl_type    ctl
);

   ssig_pkg::step_type  pc_ff;
   ssig_pkg::step_type  pc_in;
   ssig_pkg::uword_type word;
   logic                take;
   logic                stall;

   // fetch the control word of this step
   assign word = ssig_pkg::ucode(pc_ff);
   assign ctl  = word.ctl;

   // branch condition
   always_comb begin
      unique case (word.cond)
         ssig_pkg::COND_ALWAYS: take = 1'b1;
         ssig_pkg::COND_ACCEPT: take = status.req_valid;
         ssig_pkg::COND_LAST:   take = status.last;
         default:               take = 1'b1;
      endcase
   end

   // hold the step while the output register is full
   assign stall = word.ctl.emit && !status.slot_free;

   // next step address
   always_comb begin
      priority if (stall) begin
         pc_in = pc_ff;
      end else if (take) begin
         pc_in = word.jump_to;
      end else begin
         pc_in = word.next_to;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= ssig_pkg::STEP_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

// File: rtl/core/square_spiral_index_generator.sv
// Square spiral tile index generator. A request names a centre tile by its
// linear index and a count of spiral steps; the block returns the centre
// index, then the index of each tile on a square spiral going right, down
// (one row less), left and up with leg lengths 1,1,2,2,3,3 and so on, one
// transaction per tile, tlast on the final one. Indexes are row*width+col
// in 18-bit two's complement with no bounds check, so they may go negative
// or wrap. The row width register (csr) reads 0 as 1 and is capped at
// MAX_ROW_WIDTH; counts above MAX_STEPS are capped. Once the request is
// taken, the microcoded sequencer emits one index per cycle while the
// output register is free to take it; output backpressure holds the walk.
// A new request is taken only after the last index of the previous one
// has been loaded into the output register.
module square_spiral_index_generator #(
   parameter int MAX_STEPS     = ssig_pkg::MAX_STEPS_DEF,
   parameter int MAX_ROW_WIDTH = ssig_pkg::MAX_ROW_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // request: [15:0] center_index, [21:16] tiles_needed, [23:22] zero
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,
   // response: [17:0] tile_index, [23:18] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,
   output logic        rsp_tlast,
   // row width register
   input  logic        csr_wen,
   input  logic [8:0]  csr_wdata
);

   localparam int STEP_W = $clog2(MAX_STEPS + 1);
   localparam int RUN_W  = $clog2(MAX_STEPS + 2);
   localparam int WID_W  = $clog2(MAX_ROW_WIDTH + 1);
   localparam int IDX_W  = ssig_pkg::IDX_W;

   ssig_pkg::ctl_type    ctl;
   ssig_pkg::status_type status;

   logic [ssig_pkg::CENTER_W-1:0] req_center;
   logic [ssig_pkg::NEED_W-1:0]   req_need;
   logic                          req_fire;
   logic                          slot_free;
   logic                          emit_go;
   logic                          move_go;
   logic                          last_now;
   logic [IDX_W-1:0]              idx_step;
   logic [IDX_W-1:0]              width_ext;
   logic [WID_W-1:0]              width_clamp;
   logic [STEP_W-1:0]             need_clamp;
   logic [RUN_W-1:0]              sir_inc;

   logic [ssig_pkg::CFG_W-1:0] row_width_ff, row_width_in;
   logic [WID_W-1:0]           width_ff, width_in;
   logic [IDX_W-1:0]           idx_ff, idx_in;
   logic [STEP_W-1:0]          steps_left_ff, steps_left_in;
   ssig_pkg::heading_type      heading_ff, heading_in;
   logic [RUN_W-1:0]           run_len_ff, run_len_in;
   logic [RUN_W-1:0]           sir_ff, sir_in;
   logic                       leg_ff, leg_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]           rsp_idx_ff, rsp_idx_in;
   logic                       rsp_last_ff, rsp_last_in;

   // request fields
   assign req_center = req_tdata[15:0];
   assign req_need   = req_tdata[21:16];

   // sequencer
   ssig_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctl    (ctl)
   );

   assign req_tready = ctl.accept;
   assign req_fire   = req_tvalid && ctl.accept;
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign emit_go    = ctl.emit && slot_free;
   assign move_go    = ctl.move && slot_free;
   assign last_now   = ctl.move ? (steps_left_ff == STEP_W'(1)) : (steps_left_ff == '0);

   assign status = '{req_valid: req_tvalid, slot_free: slot_free, last: last_now};

   // effective row width and step count
   always_comb begin
      priority if (row_width_ff == '0) begin
         width_clamp = WID_W'(1);
      end else if (32'(row_width_ff) > MAX_ROW_WIDTH) begin
         width_clamp = WID_W'(MAX_ROW_WIDTH);
      end else begin
         width_clamp = WID_W'(row_width_ff);
      end
      if (32'(req_need) > MAX_STEPS) begin
         need_clamp = STEP_W'(MAX_STEPS);
      end else begin
         need_clamp = STEP_W'(req_need);
      end
   end

   // index of the next tile: moving one column is +-1, one row is +-width
   assign width_ext = IDX_W'(width_ff);
   always_comb begin
      unique case (heading_ff)
         ssig_pkg::HEAD_RIGHT: idx_step = idx_ff + IDX_W'(1);
         ssig_pkg::HEAD_DOWN:  idx_step = idx_ff - width_ext;
         ssig_pkg::HEAD_LEFT:  idx_step = idx_ff - IDX_W'(1);
         ssig_pkg::HEAD_UP:    idx_step = idx_ff + width_ext;
         default:              idx_step = idx_ff;
      endcase
   end

   assign sir_inc = sir_ff + RUN_W'(1);

   // walk state
   always_comb begin
      row_width_in  = csr_wen ? csr_wdata : row_width_ff;
      width_in      = width_ff;
      idx_in        = idx_ff;
      steps_left_in = steps_left_ff;
      heading_in    = heading_ff;
      run_len_in    = run_len_ff;
      sir_in        = sir_ff;
      leg_in        = leg_ff;
      if (req_fire) begin
         width_in      = width_clamp;
         idx_in        = IDX_W'(req_center);
         steps_left_in = need_clamp;
         heading_in    = ssig_pkg::HEAD_RIGHT;
         run_len_in    = RUN_W'(1);
         sir_in        = '0;
         leg_in        = 1'b0;
      end else if (move_go) begin
         idx_in        = idx_step;
         steps_left_in = steps_left_ff - STEP_W'(1);
         if (sir_inc >= run_len_ff) begin
            sir_in     = '0;
            heading_in = ssig_pkg::heading_type'(heading_ff + 2'd1);
            leg_in     = !leg_ff;
            if (leg_ff) begin
               run_len_in = run_len_ff + RUN_W'(1);
            end
         end else begin
            sir_in = sir_inc;
         end
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_idx_in   = rsp_idx_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit_go) begin
         rsp_valid_in = 1'b1;
         rsp_idx_in   = ctl.move ? idx_step : idx_ff;
         rsp_last_in  = last_now;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_width_ff  <= ssig_pkg::ROW_WIDTH_RST;
         steps_left_ff <= '0;
         heading_ff    <= ssig_pkg::HEAD_RIGHT;
         run_len_ff    <= RUN_W'(1);
         sir_ff        <= '0;
         leg_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         row_width_ff  <= row_width_in;
         steps_left_ff <= steps_left_in;
         heading_ff    <= heading_in;
         run_len_ff    <= run_len_in;
         sir_ff        <= sir_in;
         leg_ff        <= leg_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      width_ff    <= width_in;
      idx_ff      <= idx_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(ssig_pkg::RSP_DATA_W - IDX_W)'(0), rsp_idx_ff};
   assign rsp_tlast  = rsp_last_ff;

   // checks
`include "square_spiral_index_generator_assert.svh"

   `SSIG_ASSERT_NOW(a_move_has_steps, ctl.move, steps_left_ff != '0)
   `SSIG_ASSERT_NOW(a_no_walk_after_last, rsp_valid_ff && rsp_last_ff, !ctl.move)
   `SSIG_ASSERT_NEXT(a_stall_holds_walk, ctl.move && !slot_free, $stable(idx_ff) && $stable(steps_left_ff))

endmodule

// File: verif/spiral_index_checker.sv
`timescale 1ns / 1ps

// watches request, response and csr traffic, predicts the spiral and compares
module spiral_index_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [23:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [23:0] rsp_tdata,
   input  logic        rsp_tlast,
   input  logic        csr_wen,
   input  logic [8:0]  csr_wdata,
   output int          fail_count,
   output int          tiles_pending
);

   typedef struct packed {
      logic [ssig_pkg::IDX_W-1:0] tile_index;
      logic                       last;
   } tile_type;

   tile_type                   tile_q[$];
   logic [ssig_pkg::CFG_W-1:0] row_width = ssig_pkg::ROW_WIDTH_RST;

   initial begin
      fail_count    = 0;
      tiles_pending = 0;
   end

   // append one expected tile at the tail of the queue
   function automatic void add_tile(input tile_type t);
      tile_q = {tile_q, t};
   endfunction

   // expected tiles of one request: centre first, then one per spiral step
   function automatic void walk_spiral(input logic [ssig_pkg::CENTER_W-1:0] center,
                                       input logic [ssig_pkg::NEED_W-1:0]   need);
      int                    w;
      int                    steps;
      int                    c;
      int                    col;
      int                    row;
      int                    run_len;
      int                    run_pos;
      int                    v;
      bit                    second_leg;
      ssig_pkg::heading_type dir;
      tile_type              t;
      // width 0 reads as 1, wide widths saturate
      w = row_width;
      if (w == 0) w = 1;
      if (w > ssig_pkg::MAX_ROW_WIDTH_DEF) w = ssig_pkg::MAX_ROW_WIDTH_DEF;
      steps = need;
      if (steps > ssig_pkg::MAX_STEPS_DEF) steps = ssig_pkg::MAX_STEPS_DEF;
      c   = center;
      col = c % w;
      row = c / w;
      t.tile_index = ssig_pkg::IDX_W'(c);
      t.last       = (steps == 0);
      add_tile(t);
      dir        = ssig_pkg::HEAD_RIGHT;
      run_len    = 1;
      run_pos    = 0;
      second_leg = 1'b0;
      for (int k = 1; k <= steps; k++) begin
         case (dir)
            ssig_pkg::HEAD_RIGHT: col = col + 1;
            ssig_pkg::HEAD_DOWN:  row = row - 1;
            ssig_pkg::HEAD_LEFT:  col = col - 1;
            default:              row = row + 1;
         endcase
         // no bounds check, wraps to the index width
         v = row * w + col;
         t.tile_index = v[ssig_pkg::IDX_W-1:0];
         t.last       = (k == steps);
         add_tile(t);
         // leg bookkeeping: every second turn lengthens the leg
         run_pos++;
         if (run_pos >= run_len) begin
            run_pos = 0;
            dir = (dir == ssig_pkg::HEAD_UP) ? ssig_pkg::HEAD_RIGHT
                                             : ssig_pkg::heading_type'(dir + 2'd1);
            if (second_leg) begin
               second_leg = 1'b0;
               run_len++;
            end else begin
               second_leg = 1'b1;
            end
         end
      end
   endfunction

   // sample all channels at the rising edge
   always @(posedge clock) begin
      tile_type exp_tile;
      if (reset) begin
         tile_q.delete();
         row_width     = ssig_pkg::ROW_WIDTH_RST;
         fail_count    = 0;
      end else begin
         if (csr_wen) row_width = csr_wdata;
         if (req_tvalid && req_tready)
            walk_spiral(req_tdata[ssig_pkg::CENTER_W-1:0],
                        req_tdata[ssig_pkg::CENTER_W+ssig_pkg::NEED_W-1:ssig_pkg::CENTER_W]);
         // compare each response transaction with the oldest expected tile
         if (rsp_tvalid && rsp_tready) begin
            if (tile_q.size() == 0) begin
               $error("unexpected tile_index %0d last %0b",
                      $signed(rsp_tdata[ssig_pkg::IDX_W-1:0]), rsp_tlast);
               fail_count++;
            end else begin
               exp_tile = tile_q.pop_front();
               if (rsp_tdata[ssig_pkg::IDX_W-1:0] !== exp_tile.tile_index) begin
                  $error("tile_index expected %0d actual %0d",
                         $signed(exp_tile.tile_index),
                         $signed(rsp_tdata[ssig_pkg::IDX_W-1:0]));
                  fail_count++;
               end
               if (rsp_tlast !== exp_tile.last) begin
                  $error("last expected %0b actual %0b", exp_tile.last, rsp_tlast);
                  fail_count++;
               end
            end
         end
      end
      tiles_pending = tile_q.size();
   end

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps

module tb;

   localparam int IDLE_LIMIT   = 2000;
   localparam int RANDOM_ITEMS = 10;
   localparam int NUM_PHASES   = 10;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [ssig_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [ssig_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                            rsp_tlast;
   logic                            csr_wen = 1'b0;
   logic [ssig_pkg::CFG_W-1:0]      csr_wdata = '0;

   int fail_count;
   int tiles_pending;
   int stall_cycles = 0;
   bit steady = 1'b0;

   square_spiral_index_generator dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata)
   );

   spiral_index_checker checker_i (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast),
      .csr_wen       (csr_wen),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .tiles_pending (tiles_pending)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // mostly short gaps, a few long ones
   function automatic int idle_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // response backpressure, with occasional stretches of none
   initial begin
      int hold;
      int calm_left;
      hold      = 0;
      calm_left = 0;
      forever begin
         @(negedge clock);
         if (calm_left > 0) begin
            calm_left--;
            rsp_tready = 1'b1;
         end else if (hold > 0) begin
            hold--;
            rsp_tready = 1'b0;
         end else begin
            rsp_tready = 1'b1;
            if ($urandom_range(0, 149) == 0) calm_left = $urandom_range(50, 200);
            else hold = idle_gap();
         end
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_wen) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
         if (stall_cycles >= IDLE_LIMIT) begin
            $display("square_spiral_index_generator: mismatch");
            $finish;
         end
      end
   end

   // one request transaction; valid stays high when no gap follows
   task automatic send_request(input logic [ssig_pkg::CENTER_W-1:0] center,
                               input logic [ssig_pkg::NEED_W-1:0]   need);
      int gap;
      req_tvalid = 1'b1;
      req_tdata  = {2'b00, need, center};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      gap = steady ? 0 : idle_gap();
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // stop sending and let every expected tile come back
   task automatic drain_spirals();
      req_tvalid = 1'b0;
      while (tiles_pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_row_width(input logic [ssig_pkg::CFG_W-1:0] value);
      csr_wen   = 1'b1;
      csr_wdata = value;
      @(negedge clock);
      csr_wen   = 1'b0;
   endtask

   // directed requests per width setting: extremes, wrap and negative indexes
   task automatic directed_requests(input int phase);
      case (phase)
         0: begin
            send_request(16'd0, 6'd0);
            send_request(16'hFFFF, 6'd63);
            send_request(16'd0, 6'd63);
            send_request(16'h5555, 6'h2A);
            send_request(16'hAAAA, 6'h15);
            send_request(16'd17, 6'd1);
            send_request(16'd17, 6'd2);
            send_request(16'd40, 6'd5);
         end
         1: begin
            send_request(16'd0, 6'd10);
            send_request(16'hFFFF, 6'd63);
            send_request(16'd2, 6'd8);
         end
         2: begin
            send_request(16'd255, 6'd63);
            send_request(16'hFFFF, 6'd20);
         end
         3: begin
            send_request(16'd0, 6'd63);
            send_request(16'hFFFF, 6'd30);
         end
         4: send_request(16'd5, 6'd4);
         5: send_request(16'd1, 6'd63);
         6: begin
            send_request(16'hFFFF, 6'd63);
            send_request(16'd0, 6'd63);
         end
         7: send_request(16'd300, 6'd7);
         default: ;
      endcase
   endtask

   task automatic random_requests();
      logic [ssig_pkg::CENTER_W-1:0] center;
      logic [ssig_pkg::NEED_W-1:0]   need;
      int                            r;
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         r = $urandom_range(0, 9);
         if (r == 0) center = ssig_pkg::CENTER_W'($urandom_range(0, 15));
         else if (r == 1) center = 16'hFFFF - ssig_pkg::CENTER_W'($urandom_range(0, 15));
         else center = ssig_pkg::CENTER_W'($urandom_range(0, 65535));
         // mostly short spirals, some long ones
         if ($urandom_range(0, 4) == 0) need = ssig_pkg::NEED_W'($urandom_range(13, 63));
         else need = ssig_pkg::NEED_W'($urandom_range(0, 12));
         send_request(center, need);
         if ($urandom_range(0, 14) == 0) drain_spirals();
      end
   endtask

   initial begin
      logic [ssig_pkg::CFG_W-1:0] widths [NUM_PHASES];
      widths = '{9'd16, 9'd3, 9'd256, 9'd0, 9'd1, 9'd2, 9'd511, 9'd257,
                 ssig_pkg::CFG_W'($urandom_range(3, 256)),
                 ssig_pkg::CFG_W'($urandom_range(0, 511))};
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(negedge clock);
      // one width setting per phase, written only while the block is idle
      for (int p = 0; p < NUM_PHASES; p++) begin
         steady = (p == 4);
         write_row_width(widths[p]);
         directed_requests(p);
         random_requests();
         drain_spirals();
      end
      repeat (20) @(negedge clock);
      if (fail_count == 0) begin
         $display("square_spiral_index_generator: match");
      end else begin
         $display("square_spiral_index_generator: mismatch");
      end
      $finish;
   end

endmodule

// File: square_spiral_index_generator.f
+incdir+rtl/core
rtl/core/ssig_pkg.sv
rtl/core/ssig_seq.sv
rtl/core/square_spiral_index_generator.sv
verif/spiral_index_checker.sv
verif/tb.sv
